[hdl/cmrg_pkg.sv]
// Shared types and constants for the channel mask router with gain.
// Used by every module of the block; depends on nothing.
package cmrg_pkg;

  localparam int CH_W       = 6;   // source and output channel index
  localparam int SAMPLE_W   = 24;  // Q1.23 sample and contribution
  localparam int GAIN_W     = 16;  // Q4.12 gain
  localparam int CNT_W      = 7;   // counts of channels, 0..64
  localparam int PROD_W     = 40;  // exact sample * gain product
  localparam int FRAC_W     = 12;  // fraction bits of the gain
  localparam int CFG_W      = 64;  // widest configuration register
  localparam int ADDR_W     = 2;   // configuration register index
  localparam int IN_DATA_W  = 48;  // 46 field bits padded to bytes
  localparam int OUT_DATA_W = 32;  // 30 field bits padded to bytes

  localparam int MAX_OUTPUTS_DEF = 64;
  localparam int QUEUE_DEPTH     = 4;

  localparam logic [ADDR_W-1:0] REG_ROUTE_MASK   = 2'd0;
  localparam logic [ADDR_W-1:0] REG_OUTPUT_COUNT = 2'd1;
  localparam logic [ADDR_W-1:0] REG_SOURCE_COUNT = 2'd2;

  localparam logic [CNT_W-1:0] OUTPUT_COUNT_RST = 7'd2;
  localparam logic [CNT_W-1:0] SOURCE_COUNT_RST = 7'd1;

  localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 24'sh800000;

  // Routing figures the classifier needs
  typedef struct packed {
    logic [CNT_W-1:0] total;         // set mask bits in range
    logic [CNT_W-1:0] source_count;  // 1 means mono replication
  } cmrg_cls_cfg_t;

  // One queued job: a scaled sample and the span of mask ranks it feeds
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] contribution;
    logic [CH_W-1:0]            rank_first;
    logic [CH_W-1:0]            rank_last;
  } cmrg_job_t;

endpackage

[hdl/channel_mask_router_gain.sv]
// Top level of the channel mask router with gain: configuration registers,
// in-range mask and rank map, front end, job queue and back end.
// Depends on cmrg_pkg, cmrg_front, cmrg_queue and cmrg_back.
//
//  Channel  Dir  Handshake          Payload (lowest bit first)
//  in_      in   tvalid / tready    tdata: source_channel[5:0], sample_value[29:6],
//                                          gain[45:30], zero pad [47:46]
//  out_     out  tvalid / tready    tdata: output_channel[5:0], contribution[29:6],
//                                          zero pad [31:30]; tlast: last
//  cfg_     in   wen, no wait       addr: 0 route_mask, 1 output_count, 2 source_count
//
// Rates: one input beat per clock while in_tready is high. A routed channel gives at
// most one output beat, so that stream runs at one item per cycle unless out_tready
// stalls it; a mono item gives one beat per set mask bit in range, one per cycle
// unless out_tready stalls it, set by the back end's rank walk. An input beat passes
// the product register, the job queue and the output register before it leaves.
// Reset (rst_n low, synchronous) empties all stages and loads the register
// defaults. A stalled output fills the four-entry job queue before the input
// side stalls; the rank map is registered from the configuration registers.
module channel_mask_router_gain
  import cmrg_pkg::*;
#(
  parameter int MAX_OUTPUTS = MAX_OUTPUTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // source_channel, sample_value, gain
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // output_channel, contribution
  output logic                  out_tlast,
  input  logic                  cfg_wen,
  input  logic [ADDR_W-1:0]     cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  localparam int LEVELS = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_OUTPUTS);

  logic [MAX_OUTPUTS-1:0] mask_r;
  logic [CNT_W-1:0]       output_count_r;
  logic [CNT_W-1:0]       source_count_r;

  // Rank map: in-range mask bits and their inclusive prefix counts
  logic [MAX_OUTPUTS-1:0]              em_r,   em_nxt;
  logic [MAX_OUTPUTS-1:0][CNT_W-1:0]   incl_r;
  logic [CNT_W-1:0]                    total_r;
  logic [LEVELS:0][MAX_OUTPUTS-1:0][CNT_W-1:0] lvl;
  logic [CNT_W-1:0]                    cap;

  cmrg_cls_cfg_t cls_cfg;
  cmrg_job_t     push_job;
  cmrg_job_t     head_job;
  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_vld;

  // Hold the configuration; writes to an unused index drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r         <= '0;
      output_count_r <= OUTPUT_COUNT_RST;
      source_count_r <= SOURCE_COUNT_RST;
    end else if (cfg_wen) begin
      case (cfg_addr)
        REG_ROUTE_MASK:   mask_r         <= cfg_wdata[MAX_OUTPUTS-1:0];
        REG_OUTPUT_COUNT: output_count_r <= cfg_wdata[CNT_W-1:0];
        REG_SOURCE_COUNT: source_count_r <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clip the mask to the active outputs, then prefix count it in log steps
  always_comb begin
    cap = (output_count_r > MAX_CNT) ? MAX_CNT : output_count_r;
    for (int b = 0; b < MAX_OUTPUTS; b++) begin
      em_nxt[b] = mask_r[b] && (CNT_W'(b) < cap);
      lvl[0][b] = CNT_W'(em_nxt[b]);
    end
    for (int s = 0; s < LEVELS; s++) begin
      for (int b = 0; b < MAX_OUTPUTS; b++) begin
        if (b >= (1 << s)) begin
          lvl[s+1][b] = lvl[s][b] + lvl[s][b - (1 << s)];
        end else begin
          lvl[s+1][b] = lvl[s][b];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_r    <= '0;
      incl_r  <= '0;
      total_r <= '0;
    end else begin
      em_r    <= em_nxt;
      incl_r  <= lvl[LEVELS];
      total_r <= lvl[LEVELS][MAX_OUTPUTS-1];
    end
  end

  assign cls_cfg.total        = total_r;
  assign cls_cfg.source_count = source_count_r;

  cmrg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .cls_cfg   (cls_cfg),
    .q_push    (q_push),
    .q_job     (push_job),
    .q_full    (q_full)
  );

  cmrg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .head_vld (q_vld),
    .head_job (head_job)
  );

  cmrg_back #(
    .MAX_OUTPUTS (MAX_OUTPUTS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .em         (em_r),
    .incl       (incl_r),
    .q_vld      (q_vld),
    .q_job      (head_job),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

[hdl/cmrg_front.sv]
// Front end: accepts input beats, scales by the gain, rounds, saturates and
// classifies each sample into a job for the queue. Depends on cmrg_pkg.
module cmrg_front
  import cmrg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  cmrg_cls_cfg_t        cls_cfg,
  output logic                 q_push,
  output cmrg_job_t            q_job,
  input  logic                 q_full
);

  localparam int SAMPLE_LSB = CH_W;
  localparam int GAIN_LSB   = CH_W + SAMPLE_W;
  localparam logic signed [PROD_W-1:0] ROUND_W   = 40'sd2048;
  localparam logic signed [PROD_W-1:0] SAT_MAX_W = 40'sd8388607;
  localparam logic signed [PROD_W-1:0] SAT_MIN_W = -40'sd8388608;

  logic                     s1_vld_r;
  logic [CH_W-1:0]          s1_ch_r;
  logic signed [PROD_W-1:0] s1_prod_r;

  logic signed [SAMPLE_W-1:0] in_sample;
  logic signed [GAIN_W:0]     in_gain;
  logic signed [PROD_W-1:0]   prod_nxt;
  logic signed [PROD_W-1:0]   scaled;
  logic signed [SAMPLE_W-1:0] contribution;
  logic [CNT_W-1:0]           ch_ext;
  logic [CNT_W-1:0]           total_m1;
  logic                       mono;
  logic                       drop;
  logic                       s1_adv;

  always_comb begin
    in_sample = $signed(in_tdata[SAMPLE_LSB +: SAMPLE_W]);
    in_gain   = $signed({1'b0, in_tdata[GAIN_LSB +: GAIN_W]});
    prod_nxt  = PROD_W'(in_sample * in_gain);
  end

  // Round to nearest with ties up, then clamp to the Q1.23 range
  always_comb begin
    scaled = (s1_prod_r + ROUND_W) >>> FRAC_W;
    if (scaled > SAT_MAX_W) begin
      contribution = SAT_MAX;
    end else if (scaled < SAT_MIN_W) begin
      contribution = SAT_MIN;
    end else begin
      contribution = scaled[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    mono     = (cls_cfg.source_count == CNT_W'(1));
    ch_ext   = {1'b0, s1_ch_r};
    total_m1 = cls_cfg.total - CNT_W'(1);
    drop     = (cls_cfg.total == '0) ||
               (!mono && ((ch_ext >= cls_cfg.source_count) || (ch_ext >= cls_cfg.total)));
    q_job.contribution = contribution;
    q_job.rank_first   = mono ? '0 : s1_ch_r;
    q_job.rank_last    = mono ? total_m1[CH_W-1:0] : s1_ch_r;
    q_push    = s1_vld_r && !drop && !q_full;
    s1_adv    = s1_vld_r && (drop || !q_full);
    in_tready = !s1_vld_r || s1_adv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_ch_r   <= in_tdata[CH_W-1:0];
      s1_prod_r <= prod_nxt;
    end
  end

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !s1_adv) |-> !in_tready)
    else $error("input taken while the scaling stage is stalled");

  a_push_only_when_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (s1_vld_r && !q_full))
    else $error("job pushed into a full queue");

endmodule

[hdl/cmrg_queue.sv]
// Short job queue between the classifying front end and the emitting back end.
// Register based, first in first out. Depends on cmrg_pkg.
module cmrg_queue
  import cmrg_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cmrg_job_t push_job,
  output logic      full,
  input  logic      pop,
  output logic      head_vld,
  output cmrg_job_t head_job
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0]  LAST_IDX = AW'(DEPTH - 1);
  localparam logic [AW:0]    DEPTH_C  = (AW + 1)'(DEPTH);

  cmrg_job_t       slot_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]     count_r,  count_nxt;

  always_comb begin
    full       = (count_r == DEPTH_C);
    head_vld   = (count_r != '0);
    head_job   = slot_r[rd_ptr_r];
    wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + AW'(1);
    rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + AW'(1);
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (AW + 1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (AW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

[hdl/cmrg_back.sv]
// Back end: walks the rank span of the head job, maps each rank to its output
// channel through the prefix counts, and drives the output register. Uses cmrg_pkg.
module cmrg_back
  import cmrg_pkg::*;
#(
  parameter int MAX_OUTPUTS = MAX_OUTPUTS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic [MAX_OUTPUTS-1:0]                 em,
  input  logic [MAX_OUTPUTS-1:0][CNT_W-1:0]      incl,
  input  logic                                   q_vld,
  input  cmrg_job_t                              q_job,
  output logic                                   q_pop,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [OUT_DATA_W-1:0]                  out_tdata,
  output logic                                   out_tlast
);

  localparam int PAD_W = OUT_DATA_W - CH_W - SAMPLE_W;

  logic                       mid_r;
  logic [CH_W-1:0]            rank_r;
  logic                       out_vld_r;
  logic [CH_W-1:0]            out_ch_r;
  logic signed [SAMPLE_W-1:0] out_contrib_r;
  logic                       out_last_r;

  logic [CH_W-1:0]        cur;
  logic [CNT_W-1:0]       target;
  logic [MAX_OUTPUTS-1:0] sel;
  logic [CH_W-1:0]        pos;
  logic                   emit;
  logic                   at_last;

  // The rank-th set bit is the one whose inclusive count equals rank + 1
  always_comb begin
    cur    = mid_r ? rank_r : q_job.rank_first;
    target = {1'b0, cur} + CNT_W'(1);
    pos    = '0;
    for (int b = 0; b < MAX_OUTPUTS; b++) begin
      sel[b] = em[b] && (incl[b] == target);
      if (sel[b]) begin
        pos = pos | CH_W'(b);
      end
    end
    at_last = (cur == q_job.rank_last);
    emit    = q_vld && (!out_vld_r || out_tready);
    q_pop   = emit && at_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (emit) begin
        mid_r <= !at_last;
      end
      if (!out_vld_r || out_tready) begin
        out_vld_r <= q_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rank_r        <= cur + CH_W'(1);
      out_ch_r      <= pos;
      out_contrib_r <= q_job.contribution;
      out_last_r    <= at_last;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_contrib_r, out_ch_r};
  assign out_tlast  = out_last_r;

  a_mid_keeps_head: assert property (@(posedge clk) disable iff (!rst_n)
    mid_r |-> q_vld)
    else $error("job in progress left the queue head");

  a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_vld && emit))
    else $error("queue popped without an emitted last beat");

endmodule
